@@ rtl/siptd_pkg.sv @@
`timescale 1ns / 1ps

package siptd_pkg;

    localparam int MAX_FIELD_DEF = 32;
    localparam int VALUE_W       = 32;
    localparam int MIN_WIDTH_W   = 6;
    localparam int CHAR_W        = 8;
    localparam int DIGIT_W       = 4;
    localparam int DIG_MAX       = 10;
    localparam int ND_W          = 4;

    // floor(x / 10) == (x * RECIP10) >> RECIP_SHIFT for every 32-bit x
    localparam logic [VALUE_W-1:0] RECIP10     = 32'hCCCC_CCCD;
    localparam int                 RECIP_SHIFT = 35;

    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_BLANK = 8'h20;

    typedef struct packed {
        logic               neg;
        logic [VALUE_W-1:0] mag;
    } t_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_PAD,
        ST_SIGN,
        ST_DIGIT
    } t_state;

endpackage

@@ rtl/signed_int_to_padded_decimal.sv @@
`timescale 1ns / 1ps

// Signed 32-bit integer to right-aligned decimal ASCII text.
// Input channel: i_valid / o_ready with i_value; one beat per number.
// Output channel: o_valid / i_ready with o_char_code and o_last; one beat per
// character, most significant first: blanks up to the minimum width, a minus
// sign for negative values, then the digits. o_last marks the final digit.
// Config channel: i_cfg_valid / o_cfg_ready with i_min_width (always ready);
// write it only while no number is in flight. Widths above MAX_FIELD saturate.
// A two-entry queue holds accepted numbers while the converter works, so the
// input side keeps accepting while the output side stalls, until the queue is
// full. Steps per number: take it from the queue, then one decimal digit
// (1 to 10) per cycle in the divide-by-ten unit, then one character per cycle
// while i_ready is high, with an idle step after the blanks (or before the
// first character when there are no blanks). The next number is taken from
// the queue only after the last digit of this one has been registered. A
// stall on i_ready holds the output register and freezes the emitter. Reset
// (synchronous, active low) empties the queue, drops any number in progress
// and sets the minimum width to 0.

module signed_int_to_padded_decimal #(
    parameter int MAX_FIELD = siptd_pkg::MAX_FIELD_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [siptd_pkg::VALUE_W-1:0]     i_value,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [siptd_pkg::CHAR_W-1:0]      o_char_code,
    output logic                              o_last,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [siptd_pkg::MIN_WIDTH_W-1:0] i_min_width
);

    logic [siptd_pkg::MIN_WIDTH_W-1:0] r_min_width;
    logic                              w_item_valid;
    siptd_pkg::t_item                  w_item;
    logic                              w_pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_width <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_min_width <= i_min_width;
        end
    end

    siptd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_value      (i_value),
        .o_item_valid (w_item_valid),
        .o_item       (w_item),
        .i_pop        (w_pop)
    );

    siptd_back #(
        .MAX_FIELD (MAX_FIELD)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_min_width  (r_min_width),
        .i_item_valid (w_item_valid),
        .i_item       (w_item),
        .o_pop        (w_pop),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_char_code  (o_char_code),
        .o_last       (o_last)
    );

`ifndef ASSERT_OFF
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_item_valid)
        else $error("queue popped while empty");

    a_last_is_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |->
            (o_char_code >= siptd_pkg::CH_ZERO && o_char_code <= siptd_pkg::CH_NINE))
        else $error("final character is not a digit");

    a_minus_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_char_code == siptd_pkg::CH_MINUS) |-> !o_last)
        else $error("minus sign flagged as final character");
`endif

endmodule

@@ rtl/siptd_front.sv @@
`timescale 1ns / 1ps

module siptd_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [siptd_pkg::VALUE_W-1:0] i_value,
    output logic                        o_item_valid,
    output siptd_pkg::t_item            o_item,
    input  logic                        i_pop
);

    siptd_pkg::t_item r_q [2];
    logic             r_wp;
    logic             r_rp;
    logic [1:0]       r_cnt;
    logic             w_push;
    siptd_pkg::t_item w_cls;

    // split sign and magnitude; the most negative value wraps to 2^31 unsigned
    always_comb begin
        w_cls.neg = i_value[siptd_pkg::VALUE_W-1];
        w_cls.mag = w_cls.neg ? (~i_value + 32'd1) : i_value;
    end

    assign o_ready      = (r_cnt != 2'd2);
    assign w_push       = i_valid && o_ready;
    assign o_item_valid = (r_cnt != 2'd0);
    assign o_item       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_cls;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            case ({w_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

@@ rtl/siptd_back.sv @@
`timescale 1ns / 1ps

module siptd_back #(
    parameter int MAX_FIELD = siptd_pkg::MAX_FIELD_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [siptd_pkg::MIN_WIDTH_W-1:0] i_min_width,
    input  logic                              i_item_valid,
    input  siptd_pkg::t_item                  i_item,
    output logic                              o_pop,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [siptd_pkg::CHAR_W-1:0]      o_char_code,
    output logic                              o_last
);

    localparam int PW = $clog2(MAX_FIELD + 1);

    siptd_pkg::t_state r_state;
    siptd_pkg::t_state n_state;

    logic [siptd_pkg::VALUE_W-1:0]  r_mag;
    logic                           r_neg;
    logic [siptd_pkg::ND_W-1:0]     r_nd;
    logic [siptd_pkg::DIGIT_W-1:0]  r_dig [siptd_pkg::DIG_MAX];
    logic [PW-1:0]                  r_pad;
    logic                           r_ov;
    logic [siptd_pkg::CHAR_W-1:0]   r_char;
    logic                           r_last;

    logic                           w_adv;
    logic                           w_emit;
    logic [siptd_pkg::CHAR_W-1:0]   w_char;
    logic                           w_lst;
    logic                           w_shift_dn;
    logic [2*siptd_pkg::VALUE_W-1:0] w_prod;
    logic [siptd_pkg::VALUE_W-1:0]  w_quo;
    logic [siptd_pkg::VALUE_W-1:0]  w_rem;
    logic [PW-1:0]                  w_width;
    logic [PW-1:0]                  w_text_len;
    logic [PW-1:0]                  w_pad;

    assign w_adv = !r_ov || i_ready;

    // one digit per cycle: quotient by reciprocal, remainder by shift-add
    assign w_prod = {{siptd_pkg::VALUE_W{1'b0}}, r_mag} *
                    {{siptd_pkg::VALUE_W{1'b0}}, siptd_pkg::RECIP10};
    assign w_quo  = siptd_pkg::VALUE_W'(w_prod >> siptd_pkg::RECIP_SHIFT);
    assign w_rem  = r_mag - ((w_quo << 3) + (w_quo << 1));

    assign w_width = (32'(i_min_width) > 32'(MAX_FIELD)) ? PW'(MAX_FIELD)
                                                         : PW'(i_min_width);
    assign w_text_len = PW'(r_nd) + PW'(1) + PW'(r_neg);
    assign w_pad = (w_width > w_text_len) ? (w_width - w_text_len) : '0;

    always_comb begin
        n_state = r_state;
        case (r_state)
            siptd_pkg::ST_IDLE: begin
                if (i_item_valid) begin
                    n_state = siptd_pkg::ST_DIV;
                end
            end
            siptd_pkg::ST_DIV: begin
                if (w_quo == '0) begin
                    n_state = siptd_pkg::ST_PAD;
                end
            end
            siptd_pkg::ST_PAD: begin
                if (r_pad == '0) begin
                    n_state = r_neg ? siptd_pkg::ST_SIGN : siptd_pkg::ST_DIGIT;
                end
            end
            siptd_pkg::ST_SIGN: begin
                if (w_adv) begin
                    n_state = siptd_pkg::ST_DIGIT;
                end
            end
            siptd_pkg::ST_DIGIT: begin
                if (w_adv && r_nd == siptd_pkg::ND_W'(1)) begin
                    n_state = siptd_pkg::ST_IDLE;
                end
            end
            default: n_state = siptd_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_pop      = 1'b0;
        w_emit     = 1'b0;
        w_char     = siptd_pkg::CH_BLANK;
        w_lst      = 1'b0;
        w_shift_dn = 1'b0;
        case (r_state)
            siptd_pkg::ST_IDLE: begin
                o_pop = i_item_valid;
            end
            siptd_pkg::ST_PAD: begin
                w_emit = w_adv && (r_pad != '0);
            end
            siptd_pkg::ST_SIGN: begin
                w_emit = w_adv;
                w_char = siptd_pkg::CH_MINUS;
            end
            siptd_pkg::ST_DIGIT: begin
                w_emit     = w_adv;
                w_shift_dn = w_adv;
                w_char     = siptd_pkg::CH_ZERO + siptd_pkg::CHAR_W'(r_dig[0]);
                w_lst      = (r_nd == siptd_pkg::ND_W'(1));
            end
            default: begin
                o_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= siptd_pkg::ST_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_emit) begin
                r_ov <= 1'b1;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_char <= w_char;
            r_last <= w_lst;
        end
        case (r_state)
            siptd_pkg::ST_IDLE: begin
                r_mag <= i_item.mag;
                r_neg <= i_item.neg;
                r_nd  <= '0;
            end
            siptd_pkg::ST_DIV: begin
                // newest digit is the most significant so far; push it in at the front
                r_mag    <= w_quo;
                r_nd     <= r_nd + siptd_pkg::ND_W'(1);
                r_dig[0] <= w_rem[siptd_pkg::DIGIT_W-1:0];
                for (int i = 1; i < siptd_pkg::DIG_MAX; i++) begin
                    r_dig[i] <= r_dig[i-1];
                end
                r_pad <= w_pad;
            end
            siptd_pkg::ST_PAD: begin
                if (w_emit) begin
                    r_pad <= r_pad - PW'(1);
                end
            end
            siptd_pkg::ST_DIGIT: begin
                if (w_shift_dn) begin
                    r_nd <= r_nd - siptd_pkg::ND_W'(1);
                    for (int i = 0; i < siptd_pkg::DIG_MAX - 1; i++) begin
                        r_dig[i] <= r_dig[i+1];
                    end
                end
            end
            default: begin
                r_nd <= r_nd;
            end
        endcase
    end

    assign o_valid     = r_ov;
    assign o_char_code = r_char;
    assign o_last      = r_last;

endmodule

@@ verif/siptd_text_checker.sv @@
`timescale 1ns / 1ps

module siptd_text_checker
    import siptd_pkg::*;
#(
    parameter int MAX_FIELD = MAX_FIELD_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_value_valid,
    input  logic                   i_value_ready,
    input  logic [VALUE_W-1:0]     i_value,
    input  logic                   i_char_valid,
    input  logic                   i_char_ready,
    input  logic [CHAR_W-1:0]      i_char_code,
    input  logic                   i_last,
    input  logic                   i_cfg_valid,
    input  logic                   i_cfg_ready,
    input  logic [MIN_WIDTH_W-1:0] i_min_width,
    output int                     o_mismatches,
    output int                     o_pending
);

    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              last;
    } t_text_char;

    t_text_char             text_chars[$];
    t_text_char             want;
    logic [MIN_WIDTH_W-1:0] field_width = '0;
    int                     mismatches  = 0;

    assign o_mismatches = mismatches;

    initial o_pending = 0;

    // Queue the padded decimal text of one number, one entry per character.
    function automatic void predict_text(input logic [VALUE_W-1:0] value);
        logic               neg;
        logic [VALUE_W-1:0] mag;
        logic [DIGIT_W-1:0] digits[DIG_MAX];
        int                 n_digits;
        int                 text_len;
        int                 field;
        int                 n_total;
        int                 k;
        neg      = value[VALUE_W-1];
        mag      = neg ? (~value + 1'b1) : value;
        n_digits = 0;
        do begin
            digits[n_digits] = DIGIT_W'(mag % 32'd10);
            n_digits++;
            mag = mag / 32'd10;
        end while (mag != '0);
        text_len = n_digits + (neg ? 1 : 0);
        field    = (int'(field_width) > MAX_FIELD) ? MAX_FIELD : int'(field_width);
        n_total  = (field > text_len) ? field : text_len;
        k        = 0;
        for (int i = 0; i < n_total - text_len; i++) begin
            text_chars.push_back('{code: CH_BLANK, last: (k == n_total - 1)});
            k++;
        end
        if (neg) begin
            text_chars.push_back('{code: CH_MINUS, last: (k == n_total - 1)});
            k++;
        end
        for (int i = n_digits - 1; i >= 0; i--) begin
            text_chars.push_back('{code: CH_ZERO + CHAR_W'(digits[i]),
                                   last: (k == n_total - 1)});
            k++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            field_width = '0;
            text_chars.delete();
        end else begin
            // Retire the output beat first: it can never belong to a number taken at this edge.
            if (i_char_valid && i_char_ready) begin
                if (text_chars.size() == 0) begin
                    $error("char_code: expected none, got %h", i_char_code);
                    mismatches++;
                end else begin
                    want = text_chars.pop_front();
                    if (i_char_code !== want.code) begin
                        $error("char_code: expected %h, got %h", want.code, i_char_code);
                        mismatches++;
                    end
                    if (i_last !== want.last) begin
                        $error("last: expected %b, got %b", want.last, i_last);
                        mismatches++;
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                field_width = i_min_width;
            end
            if (i_value_valid && i_value_ready) begin
                predict_text(i_value);
            end
        end
        o_pending <= text_chars.size();
    end

endmodule

@@ verif/tb_signed_int_to_padded_decimal.sv @@
`timescale 1ns / 1ps

module tb_signed_int_to_padded_decimal;

    import siptd_pkg::*;

    localparam int LONG_HOLD = 600;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   in_valid  = 1'b0;
    logic                   in_ready;
    logic [VALUE_W-1:0]     in_value  = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic [CHAR_W-1:0]      out_char;
    logic                   out_last;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [MIN_WIDTH_W-1:0] cfg_width = '0;
    int                     mismatches;
    int                     pending;
    bit                     tx_quiet  = 1'b0;

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    signed_int_to_padded_decimal #(
        .MAX_FIELD (MAX_FIELD_DEF)
    ) DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_valid     (in_valid),
        .o_ready     (in_ready),
        .i_value     (in_value),
        .o_valid     (out_valid),
        .i_ready     (out_ready),
        .o_char_code (out_char),
        .o_last      (out_last),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_min_width (cfg_width)
    );

    siptd_text_checker #(
        .MAX_FIELD (MAX_FIELD_DEF)
    ) u_text_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_value_valid (in_valid),
        .i_value_ready (in_ready),
        .i_value       (in_value),
        .i_char_valid  (out_valid),
        .i_char_ready  (out_ready),
        .i_char_code   (out_char),
        .i_last        (out_last),
        .i_cfg_valid   (cfg_valid),
        .i_cfg_ready   (cfg_ready),
        .i_min_width   (cfg_width),
        .o_mismatches  (mismatches),
        .o_pending     (pending)
    );

    // Mix of near-extreme values, tiny values, raw words and values of a chosen digit count.
    function automatic logic [VALUE_W-1:0] random_value();
        logic [VALUE_W-1:0] v;
        logic [VALUE_W-1:0] lo;
        logic [VALUE_W-1:0] hi;
        int                 n;
        case ($urandom_range(0, 7))
            0: begin
                if ($urandom_range(0, 1) == 1) begin
                    v = 32'h8000_0000 + $urandom_range(0, 2);
                end else begin
                    v = 32'h7FFF_FFFF - $urandom_range(0, 2);
                end
            end
            1: begin
                v = $urandom_range(0, 20);
                if ($urandom_range(0, 1) == 1) v = -v;
            end
            2, 3, 4: begin
                v = $urandom();
            end
            default: begin
                n  = $urandom_range(1, 10);
                lo = 32'd1;
                repeat (n - 1) lo = lo * 32'd10;
                hi = (n == 10) ? 32'h7FFF_FFFF : lo * 32'd10 - 32'd1;
                if (n == 1) lo = '0;
                v = $urandom_range(hi, lo);
                if ($urandom_range(0, 1) == 1) v = -v;
            end
        endcase
        return v;
    endfunction

    task automatic send_value(input logic [VALUE_W-1:0] v);
        int gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_value <= v;
        do @(posedge clk); while (!in_ready);
    endtask

    // Drop valid and hold until every queued character has come out.
    task automatic wait_idle();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_width(input logic [MIN_WIDTH_W-1:0] w);
        cfg_valid <= 1'b1;
        cfg_width <= w;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    initial begin : sink
        int  gap;
        int  beats;
        bit  rx_quiet;
        beats    = 0;
        rx_quiet = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever begin
            if (beats % 48 == 0) rx_quiet = ($urandom_range(0, 3) == 0);
            gap = rx_quiet ? 0 : $urandom_range(0, 16);
            // Long hold-off so the input queue fills and backs up.
            if (beats == 150 || beats == 2500) gap = LONG_HOLD;
            if (gap > 0) begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            beats++;
        end
    end

    initial begin : stimulus
        logic [VALUE_W-1:0]     corners[16];
        logic [MIN_WIDTH_W-1:0] widths[7];
        corners = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'd9, 32'd10, -32'sd9, -32'sd10,
                    32'd99, 32'd100, 32'd1000000000, 32'h7FFF_FFFF, 32'h8000_0001,
                    32'h8000_0000, 32'd999999999, 32'h5555_5555, 32'hAAAA_AAAA};
        widths  = '{6'd33, 6'd63, 6'd0, 6'd1, 6'd11, 6'd12, 6'd32};
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (corners[i]) send_value(corners[i]);
        for (int p = 0; p < 8; p++) begin
            wait_idle();
            write_width((p < 7) ? widths[p] : MIN_WIDTH_W'($urandom_range(0, 63)));
            tx_quiet = ($urandom_range(0, 3) == 0);
            if (p < 7) send_value(32'h8000_0000);
            repeat (49) send_value(random_value());
        end
        wait_idle();
        repeat (40) @(posedge clk);
        if (mismatches == 0 && pending == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin : watchdog
        #20_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

@@ files.f @@
rtl/siptd_pkg.sv
rtl/siptd_front.sv
rtl/siptd_back.sv
rtl/signed_int_to_padded_decimal.sv
verif/siptd_text_checker.sv
verif/tb_signed_int_to_padded_decimal.sv
